// ----- src/trd_pkg.sv -----
// Shared types and constants for the TGA run-length pixel decoder.
package trd_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_TOTAL     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RLE_MODE        = 2'd2;

   localparam logic [2:0]  BPP_RESET         = 3'd4;
   localparam logic [31:0] PIXEL_TOTAL_RESET = 32'd1;
   localparam logic        RLE_MODE_RESET    = 1'b0;

   localparam logic [2:0] BPP_MIN = 3'd1;
   localparam logic [2:0] BPP_MAX = 3'd4;

   // Packet header byte: top bit marks a repeat packet, low bits hold count - 1.
   localparam logic [7:0] HDR_REPEAT_FLAG = 8'h80;
   localparam logic [7:0] HDR_COUNT_MASK  = 8'h7F;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_REPEAT,
      PH_LITERAL
   } phase_type;

   typedef struct packed {
      logic [31:0] pixel_value;
      logic [7:0]  run_length;
      logic        image_done;
      logic        run_clipped;
   } pixel_event_type;

endpackage

// ----- src/trd_front.sv -----
// Front end: configuration, byte classification, pixel assembly and run accounting.
module trd_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [trd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [trd_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 queue_full,
   output logic                                 push,
   output trd_pkg::pixel_event_type             push_item
);
   import trd_pkg::*;

   logic [2:0]  bpp_ff, bpp_in;
   logic [31:0] total_ff, total_in;
   logic        rle_ff, rle_in;

   phase_type   phase_ff, phase_in;
   logic [6:0]  packet_left_ff, packet_left_in;
   logic [1:0]  byte_index_ff, byte_index_in;
   logic [31:0] assembly_ff, assembly_in;
   logic [31:0] done_count_ff, done_count_in;
   logic [7:0]  run_count_ff, run_count_in;

   logic        accept;
   logic        work;
   logic        image_full;
   logic [31:0] remaining;
   logic [2:0]  eff_bpp;
   logic        pixel_complete;
   logic [31:0] merged;
   logic        in_repeat;
   logic        in_literal;
   logic        is_header;
   logic [7:0]  run_raw;
   logic        run_over;
   logic        run_ends;
   logic [7:0]  run_final;
   logic        clipped;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;

   // Configuration registers
   always_comb begin
      bpp_in   = bpp_ff;
      total_in = total_ff;
      rle_in   = rle_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BYTES_PER_PIXEL: bpp_in   = csr_write_data[2:0];
            CSR_PIXEL_TOTAL:     total_in = csr_write_data[31:0];
            CSR_RLE_MODE:        rle_in   = csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Classification
   always_comb begin
      if (bpp_ff < BPP_MIN) begin
         eff_bpp = BPP_MIN;
      end else if (bpp_ff > BPP_MAX) begin
         eff_bpp = BPP_MAX;
      end else begin
         eff_bpp = bpp_ff;
      end
   end

   assign image_full     = done_count_ff >= total_ff;
   assign remaining      = total_ff - done_count_ff;
   assign work           = accept & ~image_full;
   assign pixel_complete = ({1'b0, byte_index_ff} + 3'd1) >= eff_bpp;
   assign merged         = assembly_ff | ({24'd0, req_data_byte} << {byte_index_ff, 3'b000});
   assign in_repeat      = rle_ff && (phase_ff == PH_REPEAT);
   assign in_literal     = rle_ff && (phase_ff == PH_LITERAL);
   assign is_header      = rle_ff && !in_repeat && !in_literal;

   // Run accounting: clip against what is left of the image
   assign run_raw   = in_repeat ? run_count_ff : 8'd1;
   assign run_over  = {24'd0, run_raw} > remaining;
   assign run_ends  = {24'd0, run_raw} >= remaining;
   assign run_final = run_over ? remaining[7:0] : run_raw;

   always_comb begin
      clipped = 1'b0;
      if (in_repeat) begin
         clipped = run_over;
      end else if (in_literal) begin
         clipped = (remaining == 32'd1) && (packet_left_ff != 7'd0);
      end
   end

   assign push                  = work && pixel_complete && !is_header;
   assign push_item.pixel_value = merged;
   assign push_item.run_length  = run_final;
   assign push_item.image_done  = run_ends;
   assign push_item.run_clipped = clipped;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (work) begin
         if (!rle_ff) begin
            if (pixel_complete) phase_in = PH_HEADER;
         end else begin
            case (phase_ff)
               PH_REPEAT: begin
                  if (pixel_complete) phase_in = PH_HEADER;
               end
               PH_LITERAL: begin
                  if (pixel_complete && packet_left_ff == 7'd0) phase_in = PH_HEADER;
               end
               default: begin
                  if ((req_data_byte & HDR_REPEAT_FLAG) != 8'd0) begin
                     phase_in = PH_REPEAT;
                  end else begin
                     phase_in = PH_LITERAL;
                  end
               end
            endcase
         end
      end
   end

   // Datapath updates
   always_comb begin
      byte_index_in  = byte_index_ff;
      assembly_in    = assembly_ff;
      done_count_in  = done_count_ff;
      run_count_in   = run_count_ff;
      packet_left_in = packet_left_ff;
      if (work) begin
         if (is_header) begin
            byte_index_in = 2'd0;
            assembly_in   = 32'd0;
            if ((req_data_byte & HDR_REPEAT_FLAG) != 8'd0) begin
               run_count_in   = {1'b0, req_data_byte[6:0] & HDR_COUNT_MASK[6:0]} + 8'd1;
               packet_left_in = 7'd0;
            end else begin
               packet_left_in = req_data_byte[6:0] & HDR_COUNT_MASK[6:0];
            end
         end else if (pixel_complete) begin
            byte_index_in = 2'd0;
            assembly_in   = 32'd0;
            done_count_in = done_count_ff + {24'd0, run_final};
            if (in_literal && packet_left_ff != 7'd0) begin
               packet_left_in = packet_left_ff - 7'd1;
            end
         end else begin
            byte_index_in = byte_index_ff + 2'd1;
            assembly_in   = merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff         <= BPP_RESET;
         total_ff       <= PIXEL_TOTAL_RESET;
         rle_ff         <= RLE_MODE_RESET;
         phase_ff       <= PH_HEADER;
         packet_left_ff <= 7'd0;
         byte_index_ff  <= 2'd0;
         assembly_ff    <= 32'd0;
         done_count_ff  <= 32'd0;
         run_count_ff   <= 8'd1;
      end else begin
         bpp_ff         <= bpp_in;
         total_ff       <= total_in;
         rle_ff         <= rle_in;
         phase_ff       <= phase_in;
         packet_left_ff <= packet_left_in;
         byte_index_ff  <= byte_index_in;
         assembly_ff    <= assembly_in;
         done_count_ff  <= done_count_in;
         run_count_ff   <= run_count_in;
      end
   end

endmodule

// ----- src/trd_queue.sv -----
// Short queue of pixel runs between front end and output stage.
module trd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  trd_pkg::pixel_event_type push_item,
   input  logic                     pop,
   output trd_pkg::pixel_event_type head_item,
   output logic                     full,
   output logic                     empty
);
   import trd_pkg::*;

   pixel_event_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]         count_ff, count_in;

   assign full      = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/trd_back.sv -----
// Output stage: pulls pixel runs from the queue into the result register.
module trd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     queue_empty,
   input  trd_pkg::pixel_event_type head_item,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [31:0]              rsp_pixel_value,
   output logic [7:0]               rsp_run_length,
   output logic                     rsp_image_done,
   output logic                     rsp_run_clipped
);
   import trd_pkg::*;

   logic            rsp_valid_ff, rsp_valid_in;
   pixel_event_type rsp_item_ff;

   // Advance when the result register is free or its item is being taken
   assign pop          = !queue_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_item_ff <= head_item;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_item_ff.pixel_value;
   assign rsp_run_length  = rsp_item_ff.run_length;
   assign rsp_image_done  = rsp_item_ff.image_done;
   assign rsp_run_clipped = rsp_item_ff.run_clipped;

endmodule

// ----- src/tga_rle_pixel_decoder.sv -----
// Top level of the TGA run-length pixel decoder.
// Throughput: one data byte per cycle unless stalled, set by the front end (parser and pixel counter).
// A pixel-completing byte is queued when accepted; its run reaches rsp_* via the result register.
// A four-entry queue and the result register let the front take bytes under rsp_stall until q_full.
// Reset (synchronous, active high): header phase, other counters and assembly cleared, run count 1,
// bytes_per_pixel = 4, pixel_total = 1, raw mode. No clearing pass is needed.
module tga_rle_pixel_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [trd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [trd_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [31:0]                     rsp_pixel_value,
   output logic [7:0]                      rsp_run_length,
   output logic                            rsp_image_done,
   output logic                            rsp_run_clipped
);
   import trd_pkg::*;

   logic            q_push;
   logic            q_pop;
   logic            q_full;
   logic            q_empty;
   pixel_event_type q_push_item;
   pixel_event_type q_head_item;

   trd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .queue_full       (q_full),
      .push             (q_push),
      .push_item        (q_push_item)
   );

   trd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head_item (q_head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   trd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (q_empty),
      .head_item       (q_head_item),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_run_length  (rsp_run_length),
      .rsp_image_done  (rsp_image_done),
      .rsp_run_clipped (rsp_run_clipped)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("item pushed into a full queue");

   a_clip_ends_image: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_push_item.run_clipped) |-> q_push_item.image_done)
      else $error("clipped run does not finish the image");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_push_item.run_length != 8'd0))
      else $error("run of zero pixels");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from an empty queue");

endmodule
